FILE: src/ltps_pkg.sv
// Shared types, constants and fixed-point helpers for the landing tracking sequencer.
// Used by ltps_pid_axis and landing_tracking_pid_sequencer_core; depends on nothing.
package ltps_pkg;

    // Sequencer phases, as reported on the phase output
    typedef enum logic [2:0] {
        PH_WAITING   = 3'd0,
        PH_SEARCHING = 3'd1,
        PH_TRACKING  = 3'd2,
        PH_LANDING   = 3'd3,
        PH_LANDED    = 3'd4
    } t_phase;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_XY_PROP  = 3'd0,
        REG_GAIN_XY_INTEG = 3'd1,
        REG_GAIN_XY_DERIV = 3'd2,
        REG_GAIN_Z_PROP   = 3'd3,
        REG_GAIN_YAW_PROP = 3'd4,
        REG_TARGET_X      = 3'd5,
        REG_TARGET_Y      = 3'd6,
        REG_TARGET_YAW    = 3'd7
    } t_cfg_reg;

    // Register reset values (gains Q4.12, targets Q7.8)
    localparam logic signed [15:0] RST_GAIN_XY_PROP  = 16'sd1638;
    localparam logic signed [15:0] RST_GAIN_XY_INTEG = 16'sd41;
    localparam logic signed [15:0] RST_GAIN_XY_DERIV = 16'sd205;
    localparam logic signed [15:0] RST_GAIN_Z_PROP   = 16'sd410;
    localparam logic signed [15:0] RST_GAIN_YAW_PROP = 16'sd819;

    // Q7.8 limits: integral clamp +-100 m, near window 0.5 m,
    // low altitude 0.3 m, climb step 0.2 m
    localparam logic signed [16:0] INTEG_LIMIT = 17'sd25600;
    localparam logic signed [15:0] NEAR_LIMIT  = 16'sd128;
    localparam logic signed [15:0] LOW_ALT     = 16'sd76;
    localparam logic signed [23:0] CLIMB_STEP  = 24'sd51;

    // Width of a full PID sum of three Q.20 products
    localparam int ACC_W = 34;

    // Saturate a signed value to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -24'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    // Q.20 sum to Q7.8: round to nearest with ties up, then saturate
    function automatic logic signed [15:0] to_q8(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] v;
        logic signed [ACC_W-12:0] q;
        v = (ACC_W+1)'(acc) + (ACC_W+1)'(2048);
        q = (ACC_W-11)'(v >>> 12);
        return sat16(24'(q));
    endfunction

endpackage

FILE: src/ltps_pid_axis.sv
// One horizontal PID axis: error, clamped integral, derivative and Q7.8 command.
// Depends on ltps_pkg for saturation and rounding helpers.
module ltps_pid_axis (
    input  logic signed [15:0] i_gain_prop,
    input  logic signed [15:0] i_gain_integ,
    input  logic signed [15:0] i_gain_deriv,
    input  logic signed [15:0] i_target,
    input  logic signed [15:0] i_meas,
    input  logic signed [15:0] i_integ,
    input  logic signed [15:0] i_prev_err,
    output logic signed [15:0] o_integ,
    output logic signed [15:0] o_err,
    output logic signed [15:0] o_cmd
);
    import ltps_pkg::*;

    logic signed [16:0]      diff;
    logic signed [15:0]      err;
    logic signed [16:0]      acc;
    logic signed [15:0]      integ;
    logic signed [16:0]      der_diff;
    logic signed [15:0]      der;
    logic signed [31:0]      prod_prop;
    logic signed [31:0]      prod_integ;
    logic signed [31:0]      prod_deriv;
    logic signed [ACC_W-1:0] sum;

    // Saturated error and derivative difference
    assign diff     = 17'(i_target) - 17'(i_meas);
    assign err      = sat16(24'(diff));
    assign der_diff = 17'(err) - 17'(i_prev_err);
    assign der      = sat16(24'(der_diff));

    // Accumulate and clamp the integral
    assign acc = 17'(i_integ) + 17'(err);
    always_comb begin
        if (acc > INTEG_LIMIT) begin
            integ = 16'(INTEG_LIMIT);
        end else if (acc < -INTEG_LIMIT) begin
            integ = 16'(-INTEG_LIMIT);
        end else begin
            integ = 16'(acc);
        end
    end

    // Weighted sum of the three terms, rounded to Q7.8
    assign prod_prop  = i_gain_prop * err;
    assign prod_integ = i_gain_integ * integ;
    assign prod_deriv = i_gain_deriv * der;
    assign sum = ACC_W'(prod_prop) + ACC_W'(prod_integ) + ACC_W'(prod_deriv);

    assign o_integ = integ;
    assign o_err   = err;
    assign o_cmd   = to_q8(sum);

endmodule

FILE: src/landing_tracking_pid_sequencer_core.sv
// Landing tracking sequencer with PID velocity command, top level.
// Depends on ltps_pkg and ltps_pid_axis.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one control tick: the
//   detection and offboard flags, marker pose and yaw, and vehicle position.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result per
//   tick: send flags, position setpoint, body velocity command and the phase
//   after the tick.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes gains and targets
//   by index; it is always ready and should be used while the block is idle.
// Datapath and throughput:
//   A tick is captured in an input register, processed in one combinational
//   pass (two PID axes of three multipliers each, plus z and yaw products)
//   and lands in the result register, which drives o_out_valid. One tick per
//   cycle is sustained while the receiver keeps i_out_ready high.
// Reset:
//   Phase returns to waiting, integrals and previous errors clear, gains
//   and targets take their defaults, both pipeline stages empty.
// Stall:
//   While the receiver holds off, the result holds and one more tick can
//   wait in the input register; beyond that o_in_ready drops.
module landing_tracking_pid_sequencer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input request channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_detected,
    input  logic                               i_offboard,
    input  logic signed [15:0]                 i_marker_x,
    input  logic signed [15:0]                 i_marker_y,
    input  logic signed [15:0]                 i_marker_z,
    input  logic signed [15:0]                 i_marker_yaw,
    input  logic signed [15:0]                 i_vehicle_x,
    input  logic signed [15:0]                 i_vehicle_y,
    input  logic signed [15:0]                 i_vehicle_z,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_send_position,
    output logic                               o_send_velocity,
    output logic                               o_request_land,
    output logic signed [15:0]                 o_setpoint_x,
    output logic signed [15:0]                 o_setpoint_y,
    output logic signed [15:0]                 o_setpoint_z,
    output logic signed [15:0]                 o_velocity_x,
    output logic signed [15:0]                 o_velocity_y,
    output logic signed [15:0]                 o_velocity_z,
    output logic signed [15:0]                 o_velocity_yaw,
    output logic [2:0]                         o_phase,
    // configuration channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ltps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic signed [15:0]                 i_cfg_data
);
    import ltps_pkg::*;

    // configuration registers
    logic signed [15:0] r_gain_xy_prop;
    logic signed [15:0] r_gain_xy_integ;
    logic signed [15:0] r_gain_xy_deriv;
    logic signed [15:0] r_gain_z_prop;
    logic signed [15:0] r_gain_yaw_prop;
    logic signed [15:0] r_target_x;
    logic signed [15:0] r_target_y;
    logic signed [15:0] r_target_yaw;

    // input stage
    logic               r_in_valid;
    logic               r_in_detected;
    logic               r_in_offboard;
    logic signed [15:0] r_in_marker_x;
    logic signed [15:0] r_in_marker_y;
    logic signed [15:0] r_in_marker_z;
    logic signed [15:0] r_in_marker_yaw;
    logic signed [15:0] r_in_vehicle_x;
    logic signed [15:0] r_in_vehicle_y;
    logic signed [15:0] r_in_vehicle_z;

    // controller state
    t_phase             r_phase;
    t_phase             n_phase;
    logic signed [15:0] r_integ_x;
    logic signed [15:0] r_integ_y;
    logic signed [15:0] r_prev_err_x;
    logic signed [15:0] r_prev_err_y;

    // result stage
    logic               r_out_valid;
    logic               r_out_send_position;
    logic               r_out_send_velocity;
    logic               r_out_request_land;
    logic signed [15:0] r_out_setpoint_x;
    logic signed [15:0] r_out_setpoint_y;
    logic signed [15:0] r_out_setpoint_z;
    logic signed [15:0] r_out_velocity_x;
    logic signed [15:0] r_out_velocity_y;
    logic signed [15:0] r_out_velocity_z;
    logic signed [15:0] r_out_velocity_yaw;
    t_phase             r_out_phase;

    // datapath and sequencer signals
    logic               advance;
    logic               near;
    logic               run_pid;
    logic               use_z;
    logic               n_send_position;
    logic               n_send_velocity;
    logic               n_request_land;
    logic signed [15:0] n_setpoint_x;
    logic signed [15:0] n_setpoint_y;
    logic signed [15:0] n_setpoint_z;
    logic signed [15:0] n_velocity_x;
    logic signed [15:0] n_velocity_y;
    logic signed [15:0] n_velocity_z;
    logic signed [15:0] n_velocity_yaw;
    logic signed [15:0] climb_z;
    logic signed [15:0] err_z;
    logic signed [15:0] err_yaw;
    logic signed [31:0] prod_z;
    logic signed [31:0] prod_yaw;
    logic signed [15:0] cmd_z;
    logic signed [15:0] cmd_yaw;
    logic signed [15:0] integ_x;
    logic signed [15:0] integ_y;
    logic signed [15:0] err_x;
    logic signed [15:0] err_y;
    logic signed [15:0] cmd_x;
    logic signed [15:0] cmd_y;

    // Handshake: move a request forward when the result slot frees up
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_xy_prop  <= RST_GAIN_XY_PROP;
            r_gain_xy_integ <= RST_GAIN_XY_INTEG;
            r_gain_xy_deriv <= RST_GAIN_XY_DERIV;
            r_gain_z_prop   <= RST_GAIN_Z_PROP;
            r_gain_yaw_prop <= RST_GAIN_YAW_PROP;
            r_target_x      <= '0;
            r_target_y      <= '0;
            r_target_yaw    <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_GAIN_XY_PROP:  r_gain_xy_prop  <= i_cfg_data;
                REG_GAIN_XY_INTEG: r_gain_xy_integ <= i_cfg_data;
                REG_GAIN_XY_DERIV: r_gain_xy_deriv <= i_cfg_data;
                REG_GAIN_Z_PROP:   r_gain_z_prop   <= i_cfg_data;
                REG_GAIN_YAW_PROP: r_gain_yaw_prop <= i_cfg_data;
                REG_TARGET_X:      r_target_x      <= i_cfg_data;
                REG_TARGET_Y:      r_target_y      <= i_cfg_data;
                REG_TARGET_YAW:    r_target_yaw    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_detected   <= i_detected;
            r_in_offboard   <= i_offboard;
            r_in_marker_x   <= i_marker_x;
            r_in_marker_y   <= i_marker_y;
            r_in_marker_z   <= i_marker_z;
            r_in_marker_yaw <= i_marker_yaw;
            r_in_vehicle_x  <= i_vehicle_x;
            r_in_vehicle_y  <= i_vehicle_y;
            r_in_vehicle_z  <= i_vehicle_z;
        end
    end

    // Horizontal PID axes
    ltps_pid_axis u_pid_x (
        .i_gain_prop  (r_gain_xy_prop),
        .i_gain_integ (r_gain_xy_integ),
        .i_gain_deriv (r_gain_xy_deriv),
        .i_target     (r_target_x),
        .i_meas       (r_in_marker_x),
        .i_integ      (r_integ_x),
        .i_prev_err   (r_prev_err_x),
        .o_integ      (integ_x),
        .o_err        (err_x),
        .o_cmd        (cmd_x)
    );

    ltps_pid_axis u_pid_y (
        .i_gain_prop  (r_gain_xy_prop),
        .i_gain_integ (r_gain_xy_integ),
        .i_gain_deriv (r_gain_xy_deriv),
        .i_target     (r_target_y),
        .i_meas       (r_in_marker_y),
        .i_integ      (r_integ_y),
        .i_prev_err   (r_prev_err_y),
        .o_integ      (integ_y),
        .o_err        (err_y),
        .o_cmd        (cmd_y)
    );

    // Proportional-only vertical and yaw loops, desired z is zero
    assign err_z    = sat16(-24'(r_in_marker_z));
    assign err_yaw  = sat16(24'(r_target_yaw) - 24'(r_in_marker_yaw));
    assign prod_z   = r_gain_z_prop * err_z;
    assign prod_yaw = r_gain_yaw_prop * err_yaw;
    assign cmd_z    = to_q8(ACC_W'(prod_z));
    assign cmd_yaw  = to_q8(ACC_W'(prod_yaw));

    assign climb_z = sat16(24'(r_in_vehicle_z) + CLIMB_STEP);
    assign near    = (r_in_marker_x < NEAR_LIMIT) && (r_in_marker_x > -NEAR_LIMIT) &&
                     (r_in_marker_y < NEAR_LIMIT) && (r_in_marker_y > -NEAR_LIMIT);

    // Sequencer: next phase, send flags and setpoints
    always_comb begin
        n_phase         = r_phase;
        n_send_position = 1'b0;
        n_request_land  = 1'b0;
        n_setpoint_x    = '0;
        n_setpoint_y    = '0;
        n_setpoint_z    = '0;
        run_pid         = 1'b0;
        use_z           = 1'b0;
        unique case (r_phase)
            PH_WAITING: begin
                if (!r_in_offboard) begin
                    n_send_position = 1'b1;
                    n_setpoint_x    = r_in_vehicle_x;
                    n_setpoint_y    = r_in_vehicle_y;
                    n_setpoint_z    = r_in_vehicle_z;
                end else begin
                    n_phase = PH_SEARCHING;
                end
            end
            PH_SEARCHING: begin
                if (r_in_detected) begin
                    n_phase = PH_TRACKING;
                end else begin
                    n_send_position = 1'b1;
                    n_setpoint_x    = r_in_vehicle_x;
                    n_setpoint_y    = r_in_vehicle_y;
                    n_setpoint_z    = climb_z;
                end
            end
            PH_TRACKING: begin
                if (!r_in_detected) begin
                    n_phase = PH_SEARCHING;
                end else if (near) begin
                    n_phase = PH_LANDING;
                end else begin
                    run_pid = 1'b1;
                end
            end
            PH_LANDING: begin
                if (!r_in_detected) begin
                    n_phase = PH_TRACKING;
                end else if (near) begin
                    if (r_in_marker_z > LOW_ALT) begin
                        run_pid = 1'b1;
                        use_z   = 1'b1;
                    end else begin
                        n_phase = PH_LANDED;
                    end
                end
                // hold position whenever offboard drops while landing
                if (!r_in_offboard) begin
                    n_send_position = 1'b1;
                    n_setpoint_x    = r_in_vehicle_x;
                    n_setpoint_y    = r_in_vehicle_y;
                    n_setpoint_z    = r_in_vehicle_z;
                end
            end
            PH_LANDED: begin
                n_request_land = 1'b1;
            end
            default: ;
        endcase
    end

    // Velocity command with swapped horizontal axes
    always_comb begin
        n_send_velocity = run_pid;
        n_velocity_x    = '0;
        n_velocity_y    = '0;
        n_velocity_z    = '0;
        n_velocity_yaw  = '0;
        if (run_pid) begin
            n_velocity_x   = cmd_y;
            n_velocity_y   = cmd_x;
            n_velocity_z   = use_z ? cmd_z : 16'sd0;
            n_velocity_yaw = cmd_yaw;
        end
    end

    // Advance the phase with each processed request; integrals and previous errors only when the PID runs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAITING;
            r_integ_x    <= '0;
            r_integ_y    <= '0;
            r_prev_err_x <= '0;
            r_prev_err_y <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            if (run_pid) begin
                r_integ_x    <= integ_x;
                r_integ_y    <= integ_y;
                r_prev_err_x <= err_x;
                r_prev_err_y <= err_y;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_send_position <= n_send_position;
            r_out_send_velocity <= n_send_velocity;
            r_out_request_land  <= n_request_land;
            r_out_setpoint_x    <= n_setpoint_x;
            r_out_setpoint_y    <= n_setpoint_y;
            r_out_setpoint_z    <= n_setpoint_z;
            r_out_velocity_x    <= n_velocity_x;
            r_out_velocity_y    <= n_velocity_y;
            r_out_velocity_z    <= n_velocity_z;
            r_out_velocity_yaw  <= n_velocity_yaw;
            r_out_phase         <= n_phase;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_send_position = r_out_send_position;
    assign o_send_velocity = r_out_send_velocity;
    assign o_request_land  = r_out_request_land;
    assign o_setpoint_x    = r_out_setpoint_x;
    assign o_setpoint_y    = r_out_setpoint_y;
    assign o_setpoint_z    = r_out_setpoint_z;
    assign o_velocity_x    = r_out_velocity_x;
    assign o_velocity_y    = r_out_velocity_y;
    assign o_velocity_z    = r_out_velocity_z;
    assign o_velocity_yaw  = r_out_velocity_yaw;
    assign o_phase         = r_out_phase;

    // Land request only ever comes out of the landed phase
    a_land_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_request_land) |-> (r_out_phase == PH_LANDED))
        else $error("land request outside landed phase");

    // Vertical velocity is only commanded while landing
    a_vz_landing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_velocity_z != 16'sd0) |->
        (r_out_send_velocity && r_out_phase == PH_LANDING))
        else $error("vertical velocity outside landing phase");

    // Integrals stay inside the clamp
    a_integ_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integ_x <= 16'sd25600) && (r_integ_x >= -16'sd25600) &&
        (r_integ_y <= 16'sd25600) && (r_integ_y >= -16'sd25600))
        else $error("integral outside clamp");

    // Integrals move only when a velocity command is produced
    a_integ_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!advance || !n_send_velocity) |=> ($stable(r_integ_x) && $stable(r_integ_y)))
        else $error("integral changed without a velocity command");

endmodule
